/* rtl/core/etwr_pkg.sv */
// ----------------------------------------------------------------------------
// etwr_pkg
// Shared types and constants for the episode tag word recognizer.
// ----------------------------------------------------------------------------
package etwr_pkg;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_LEAD  = 5'b00010,
        PH_XEPI  = 5'b00100,
        PH_SSEA  = 5'b01000,
        PH_SEPI  = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [10:0] first;
        logic [6:0]  second;
        logic        has_digit;
        logic        rejected;
    } t_word;

    localparam logic [7:0]  CH_0 = 8'h30;
    localparam logic [7:0]  CH_9 = 8'h39;
    localparam logic [7:0]  CH_X = 8'h78;
    localparam logic [7:0]  CH_E = 8'h65;
    localparam logic [7:0]  CH_S = 8'h73;

    localparam logic [10:0] FIRST_MAX     = 11'd2047;
    localparam logic [6:0]  SECOND_MAX    = 7'd127;
    localparam logic [10:0] LEAD_MIN      = 11'd101;
    localparam logic [10:0] LEAD_MAX      = 11'd1899;
    localparam logic [10:0] SEASON_MAX    = 11'd18;
    localparam logic [6:0]  EPISODE_LIMIT = 7'd100;
    localparam int          SEASON_COUNT  = 18;
    localparam int          SEASON_STRIDE = 100;

endpackage

/* rtl/core/etwr_scan.sv */
// ----------------------------------------------------------------------------
// etwr_scan
// Per-word scan state and its byte-by-byte update.
// ----------------------------------------------------------------------------
module etwr_scan
    import etwr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_word      o_word
);

    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    t_word       r_word;
    t_word       n_word;

    logic        dig;
    logic [3:0]  d;
    logic [14:0] first_acc;
    logic [10:0] first_sat;
    logic [10:0] second_acc;
    logic [6:0]  second_sat;

    always_comb begin
        dig        = (i_byte >= CH_0) && (i_byte <= CH_9);
        d          = dig ? i_byte[3:0] : 4'd0;
        first_acc  = 15'(r_word.first) * 15'd10 + 15'(d);
        first_sat  = (first_acc > 15'(FIRST_MAX)) ? FIRST_MAX : first_acc[10:0];
        second_acc = 11'(r_word.second) * 11'd10 + 11'(d);
        second_sat = (second_acc > 11'(SECOND_MAX)) ? SECOND_MAX : second_acc[6:0];

        n_pos  = (r_pos == 2'd3) ? r_pos : r_pos + 2'd1;
        n_word = r_word;
        if (!r_word.rejected) begin
            unique case (r_word.phase)
                PH_START: begin
                    if (dig) begin
                        n_word.first = 11'(d);
                        n_word.phase = PH_LEAD;
                    end else if (i_byte == CH_S) begin
                        n_word.phase = PH_SSEA;
                    end else begin
                        n_word.rejected = 1'b1;
                    end
                end
                PH_LEAD: begin
                    if (dig) begin
                        n_word.first = first_sat;
                    end else if (i_byte == CH_X && (r_pos == 2'd1 || r_pos == 2'd2)) begin
                        n_word.phase = PH_XEPI;
                    end else begin
                        n_word.rejected = 1'b1;
                    end
                end
                PH_SSEA: begin
                    if (dig) begin
                        n_word.first = first_sat;
                    end else if (i_byte == CH_E && r_pos >= 2'd2) begin
                        n_word.phase = PH_SEPI;
                    end else begin
                        n_word.rejected = 1'b1;
                    end
                end
                PH_XEPI, PH_SEPI: begin
                    if (dig) begin
                        n_word.second    = second_sat;
                        n_word.has_digit = 1'b1;
                    end else begin
                        n_word.rejected = 1'b1;
                    end
                end
                default: begin
                    n_word.rejected = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_word <= '{phase: PH_START, first: '0, second: '0, has_digit: 1'b0,
                        rejected: 1'b0};
        end else if (i_en) begin
            if (i_last) begin
                r_pos  <= 2'd0;
                r_word <= '{phase: PH_START, first: '0, second: '0, has_digit: 1'b0,
                            rejected: 1'b0};
            end else begin
                r_pos  <= n_pos;
                r_word <= n_word;
            end
        end
    end

    assign o_word = n_word;

endmodule

/* rtl/core/etwr_judge.sv */
// ----------------------------------------------------------------------------
// etwr_judge
// Final check of a finished word and extraction of season and episode.
// ----------------------------------------------------------------------------
module etwr_judge
    import etwr_pkg::*;
(
    input  t_word       i_word,
    output logic        o_matched,
    output logic [4:0]  o_season_num,
    output logic [6:0]  o_episode_num
);

    logic [4:0]  lead_sea;
    logic [10:0] lead_base;
    logic [10:0] lead_epi;

    // season of the whole-number form by parallel threshold compares
    always_comb begin
        lead_sea  = 5'd0;
        lead_base = 11'd0;
        for (int k = 1; k <= SEASON_COUNT; k++) begin
            if (i_word.first >= 11'(k * SEASON_STRIDE)) begin
                lead_sea  = 5'(k);
                lead_base = 11'(k * SEASON_STRIDE);
            end
        end
        lead_epi = i_word.first - lead_base;
    end

    always_comb begin
        o_matched     = 1'b0;
        o_season_num  = 5'd0;
        o_episode_num = 7'd0;
        if (!i_word.rejected) begin
            unique case (i_word.phase)
                PH_LEAD: begin
                    if (i_word.first >= LEAD_MIN && i_word.first <= LEAD_MAX) begin
                        o_matched     = 1'b1;
                        o_season_num  = lead_sea;
                        o_episode_num = lead_epi[6:0];
                    end
                end
                PH_XEPI, PH_SEPI: begin
                    if (i_word.first >= 11'd1 && i_word.first <= SEASON_MAX &&
                        i_word.has_digit && i_word.second < EPISODE_LIMIT) begin
                        o_matched     = 1'b1;
                        o_season_num  = i_word.first[4:0];
                        o_episode_num = i_word.second;
                    end
                end
                default: begin
                    o_matched = 1'b0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/episode_tag_word_recognizer.sv */
// ----------------------------------------------------------------------------
// episode_tag_word_recognizer
// Byte-serial recognizer of season/episode tag words.
// ----------------------------------------------------------------------------
// Takes one byte of a lower-case word per transaction, with i_last_byte on the
// final byte, and gives one result transaction per word: o_matched plus the
// season and episode, both zero when the word is no tag. Accepted forms are a
// number 101..1899, digits 'x' digits, and 's' digits 'e' digits. A byte goes
// through an input register and one pass of scan logic into the result
// register, so one byte is taken every cycle and the result of a word is
// loaded into the result register when its last byte leaves the input
// register; only a held result stalls the input.
module episode_tag_word_recognizer
    import etwr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_matched,
    output logic [4:0] o_season_num,
    output logic [6:0] o_episode_num
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_out_valid;
    logic       r_matched;
    logic [4:0] r_season;
    logic [6:0] r_episode;

    logic       adv;
    logic       fire;
    t_word      word;
    logic       n_matched;
    logic [4:0] n_season;
    logic [6:0] n_episode;

    assign adv     = !r_last || !r_out_valid || i_ready;
    assign fire    = r_in_valid && adv;
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte_in;
            r_last <= i_last_byte;
        end
    end

    etwr_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (fire),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_word  (word)
    );

    etwr_judge u_judge (
        .i_word        (word),
        .o_matched     (n_matched),
        .o_season_num  (n_season),
        .o_episode_num (n_episode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_last) begin
            r_matched <= n_matched;
            r_season  <= n_season;
            r_episode <= n_episode;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_matched     = r_matched;
    assign o_season_num  = r_season;
    assign o_episode_num = r_episode;

endmodule
